/* sv/lidar_scan_sector_query_defines.svh */
// Assertion macros used by the lidar scan sector query checker.
`ifndef LIDAR_SCAN_SECTOR_QUERY_DEFINES_SVH
`define LIDAR_SCAN_SECTOR_QUERY_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSSQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lssq check failed");

// Consequent checked in the cycle after the antecedent.
`define LSSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lssq check failed");

`endif

/* sv/lssq_pkg.sv */
// Types, constants and helpers of the lidar scan sector query block.
`timescale 1ns / 1ps
package lssq_pkg;

  localparam int unsigned ANGLE_W    = 13;
  localparam int unsigned TOL_W      = 12;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ANGLE_W-1:0] FULL_TURN = 13'd5760;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 13'd2880;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTOR_START = 3'd0,
    CFG_SECTOR_END   = 3'd1,
    CFG_TARGET_ANGLE = 3'd2,
    CFG_ANGLE_TOL    = 3'd3,
    CFG_OBST_THRESH  = 3'd4,
    CFG_MIN_RANGE    = 3'd5,
    CFG_MAX_RANGE    = 3'd6
  } cfg_idx_t;

  localparam logic [ANGLE_W-1:0] RST_SECTOR_START = 13'd0;
  localparam logic [ANGLE_W-1:0] RST_SECTOR_END   = 13'd5759;
  localparam logic [ANGLE_W-1:0] RST_TARGET_ANGLE = 13'd0;
  localparam logic [TOL_W-1:0]   RST_ANGLE_TOL    = 12'd16;
  localparam logic [DIST_W-1:0]  RST_OBST_THRESH  = 16'd500;
  localparam logic [DIST_W-1:0]  RST_MIN_RANGE    = 16'd150;
  localparam logic [DIST_W-1:0]  RST_MAX_RANGE    = 16'd12000;

  // classification of one scan point
  typedef struct packed {
    logic             valid;
    logic             in_sector;
    logic             near_target;
    logic [TOL_W-1:0] diff;
  } point_info_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] sector_start;
    logic [ANGLE_W-1:0] sector_end;
    logic [ANGLE_W-1:0] target_angle;
    logic [TOL_W-1:0]   angle_tol;
    logic [DIST_W-1:0]  min_range;
    logic [DIST_W-1:0]  max_range;
  } eval_cfg_t;

  function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] a);
    wrap_angle = (a >= FULL_TURN) ? a - FULL_TURN : a;
  endfunction

endpackage

/* sv/lssq_point_eval.sv */
// Range check, sector test and target angle distance for one scan point.
`timescale 1ns / 1ps
module lssq_point_eval (
  input  logic [lssq_pkg::ANGLE_W-1:0] angle,
  input  logic [lssq_pkg::DIST_W-1:0]  distance,
  input  lssq_pkg::eval_cfg_t          cfg,
  output lssq_pkg::point_info_t        info
);

  logic [lssq_pkg::ANGLE_W-1:0] a_w;
  logic [lssq_pkg::ANGLE_W-1:0] t_w;
  logic [lssq_pkg::ANGLE_W-1:0] abs_diff;
  logic [lssq_pkg::ANGLE_W-1:0] circ_diff;

  always_comb begin
    a_w = lssq_pkg::wrap_angle(angle);
    t_w = lssq_pkg::wrap_angle(cfg.target_angle);
    abs_diff = (a_w >= t_w) ? a_w - t_w : t_w - a_w;
    circ_diff = (abs_diff > lssq_pkg::HALF_TURN) ? lssq_pkg::FULL_TURN - abs_diff : abs_diff;

    info.valid = (distance != '0) && (distance >= cfg.min_range) &&
                 (distance <= cfg.max_range);
    if (cfg.sector_start <= cfg.sector_end) begin
      info.in_sector = (a_w >= cfg.sector_start) && (a_w <= cfg.sector_end);
    end else begin
      // sector wraps through zero
      info.in_sector = (a_w >= cfg.sector_start) || (a_w <= cfg.sector_end);
    end
    info.diff = circ_diff[lssq_pkg::TOL_W-1:0];
    info.near_target = (info.diff <= cfg.angle_tol);
  end

endmodule

/* sv/lidar_scan_sector_query.sv */
// Top level of the lidar scan sector query block.
// Usage:
//   Input channel (in_*): one scan point per word, angle in 1/16 degree, distance
//   in mm, in_scan_last on the final point of a scan. Result channel (out_*): one
//   word per scan with the sector minimum, the target lookup, the valid point
//   count and the obstacle flag. Configuration (cfg_*): write-only registers; the
//   user must write them between scans, the block itself does not enforce this.
//   Throughput: one point per cycle while in_stall is low. Each point passes an
//   input register and then the combinational range/sector/target logic into the
//   accumulators. The last point of a scan passes the input register and, once it
//   fires, the result register that drives out_valid and the result word.
//   Stall: while a result is held by out_stall, points that are not last keep
//   flowing into the accumulators; a last point waits in the input register and
//   in_stall rises until the result slot frees.
//   Reset: configuration returns to its defaults, accumulators and both valid
//   flags clear; no result is pending after reset.
`timescale 1ns / 1ps
module lidar_scan_sector_query (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lssq_pkg::ANGLE_W-1:0]      in_sample_angle,
  input  logic [lssq_pkg::DIST_W-1:0]       in_sample_distance,
  input  logic                              in_scan_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lssq_pkg::DIST_W-1:0]       out_sector_min,
  output logic                              out_sector_found,
  output logic [lssq_pkg::DIST_W-1:0]       out_target_distance,
  output logic                              out_target_found,
  output logic [lssq_pkg::COUNT_W-1:0]      out_valid_count,
  output logic                              out_obstacle,
  input  logic                              cfg_we,
  input  logic [lssq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lssq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic [lssq_pkg::ANGLE_W-1:0] sector_start_r;
  logic [lssq_pkg::ANGLE_W-1:0] sector_end_r;
  logic [lssq_pkg::ANGLE_W-1:0] target_angle_r;
  logic [lssq_pkg::TOL_W-1:0]   angle_tol_r;
  logic [lssq_pkg::DIST_W-1:0]  obst_thresh_r;
  logic [lssq_pkg::DIST_W-1:0]  min_range_r;
  logic [lssq_pkg::DIST_W-1:0]  max_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_start_r <= lssq_pkg::RST_SECTOR_START;
      sector_end_r   <= lssq_pkg::RST_SECTOR_END;
      target_angle_r <= lssq_pkg::RST_TARGET_ANGLE;
      angle_tol_r    <= lssq_pkg::RST_ANGLE_TOL;
      obst_thresh_r  <= lssq_pkg::RST_OBST_THRESH;
      min_range_r    <= lssq_pkg::RST_MIN_RANGE;
      max_range_r    <= lssq_pkg::RST_MAX_RANGE;
    end else if (cfg_we) begin
      unique case (lssq_pkg::cfg_idx_t'(cfg_index))
        lssq_pkg::CFG_SECTOR_START: sector_start_r <= cfg_data[lssq_pkg::ANGLE_W-1:0];
        lssq_pkg::CFG_SECTOR_END:   sector_end_r   <= cfg_data[lssq_pkg::ANGLE_W-1:0];
        lssq_pkg::CFG_TARGET_ANGLE: target_angle_r <= cfg_data[lssq_pkg::ANGLE_W-1:0];
        lssq_pkg::CFG_ANGLE_TOL:    angle_tol_r    <= cfg_data[lssq_pkg::TOL_W-1:0];
        lssq_pkg::CFG_OBST_THRESH:  obst_thresh_r  <= cfg_data;
        lssq_pkg::CFG_MIN_RANGE:    min_range_r    <= cfg_data;
        lssq_pkg::CFG_MAX_RANGE:    max_range_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                          s1_valid_r;
  logic [lssq_pkg::ANGLE_W-1:0]  s1_angle_r;
  logic [lssq_pkg::DIST_W-1:0]   s1_dist_r;
  logic                          s1_last_r;
  logic                          s1_fire;
  logic                          in_accept;

  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_angle_r <= in_sample_angle;
      s1_dist_r  <= in_sample_distance;
      s1_last_r  <= in_scan_last;
    end
  end

  // point classification
  lssq_pkg::eval_cfg_t   eval_cfg;
  lssq_pkg::point_info_t info;

  assign eval_cfg = '{
    sector_start: sector_start_r,
    sector_end:   sector_end_r,
    target_angle: target_angle_r,
    angle_tol:    angle_tol_r,
    min_range:    min_range_r,
    max_range:    max_range_r
  };

  lssq_point_eval u_eval (
    .angle    (s1_angle_r),
    .distance (s1_dist_r),
    .cfg      (eval_cfg),
    .info     (info)
  );

  // scan accumulators
  logic [lssq_pkg::DIST_W-1:0]  run_min_r,   run_min_nxt;
  logic                         min_seen_r,  min_seen_nxt;
  logic [lssq_pkg::TOL_W-1:0]   best_diff_r, best_diff_nxt;
  logic [lssq_pkg::DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic                         best_seen_r, best_seen_nxt;
  logic [lssq_pkg::COUNT_W-1:0] count_r,     count_nxt;
  logic [lssq_pkg::DIST_W-1:0]  bound;
  logic                         scan_done;

  always_comb begin
    run_min_nxt   = run_min_r;
    min_seen_nxt  = min_seen_r;
    best_diff_nxt = best_diff_r;
    best_dist_nxt = best_dist_r;
    best_seen_nxt = best_seen_r;
    count_nxt     = count_r;
    bound         = min_seen_r ? run_min_r : max_range_r;
    if (s1_fire && info.valid) begin
      if (count_r != '1) begin
        count_nxt = count_r + 1'b1;
      end
      if (info.in_sector && (s1_dist_r < bound)) begin
        run_min_nxt  = s1_dist_r;
        min_seen_nxt = 1'b1;
      end
      if (info.near_target && (!best_seen_r || (info.diff < best_diff_r))) begin
        best_diff_nxt = info.diff;
        best_dist_nxt = s1_dist_r;
        best_seen_nxt = 1'b1;
      end
    end
  end

  assign scan_done = s1_fire && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_seen_r  <= 1'b0;
      best_seen_r <= 1'b0;
      count_r     <= '0;
    end else if (scan_done) begin
      min_seen_r  <= 1'b0;
      best_seen_r <= 1'b0;
      count_r     <= '0;
    end else begin
      min_seen_r  <= min_seen_nxt;
      best_seen_r <= best_seen_nxt;
      count_r     <= count_nxt;
    end
  end

  // values only read while the matching seen flag is set
  always_ff @(posedge clk) begin
    run_min_r   <= run_min_nxt;
    best_diff_r <= best_diff_nxt;
    best_dist_r <= best_dist_nxt;
  end

  // result register
  logic                         out_valid_r;
  logic [lssq_pkg::DIST_W-1:0]  sector_min_r;
  logic                         sector_found_r;
  logic [lssq_pkg::DIST_W-1:0]  target_dist_r;
  logic                         target_found_r;
  logic [lssq_pkg::COUNT_W-1:0] valid_count_r;
  logic                         obstacle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      sector_min_r   <= min_seen_nxt ? run_min_nxt : '0;
      sector_found_r <= min_seen_nxt;
      target_dist_r  <= best_seen_nxt ? best_dist_nxt : '0;
      target_found_r <= best_seen_nxt;
      valid_count_r  <= count_nxt;
      obstacle_r     <= min_seen_nxt && (run_min_nxt != '0) &&
                        (run_min_nxt < obst_thresh_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sector_min      = sector_min_r;
  assign out_sector_found    = sector_found_r;
  assign out_target_distance = target_dist_r;
  assign out_target_found    = target_found_r;
  assign out_valid_count     = valid_count_r;
  assign out_obstacle        = obstacle_r;

endmodule

/* sv/lssq_checker.sv */
// Port-level checks of the lidar scan sector query result channel.
`timescale 1ns / 1ps
`include "lidar_scan_sector_query_defines.svh"
module lssq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lssq_pkg::DIST_W-1:0]  out_sector_min,
  input logic                         out_sector_found,
  input logic [lssq_pkg::DIST_W-1:0]  out_target_distance,
  input logic                         out_target_found,
  input logic                         out_obstacle
);

  `LSSQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sector_min) && $stable(out_target_distance))
  `LSSQ_ASSERT_NOW(a_obst_needs_sector, out_valid && out_obstacle, out_sector_found)
  `LSSQ_ASSERT_NOW(a_sector_zero, out_valid && !out_sector_found, out_sector_min == '0)
  `LSSQ_ASSERT_NOW(a_target_zero, out_valid && !out_target_found, out_target_distance == '0)

endmodule

bind lidar_scan_sector_query lssq_checker u_lssq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_sector_min      (out_sector_min),
  .out_sector_found    (out_sector_found),
  .out_target_distance (out_target_distance),
  .out_target_found    (out_target_found),
  .out_obstacle        (out_obstacle)
);

/* sim/tb_lidar_scan_sector_query.sv */
// Testbench for lidar_scan_sector_query: random and directed scans checked against a predictor.
`timescale 1ns / 1ps
module tb_lidar_scan_sector_query;

  localparam int TURN = int'(lssq_pkg::FULL_TURN);
  localparam int HALF = int'(lssq_pkg::HALF_TURN);
  localparam int COUNT_SAT = (1 << lssq_pkg::COUNT_W) - 1;

  typedef struct {
    logic [lssq_pkg::ANGLE_W-1:0] angle;
    logic [lssq_pkg::DIST_W-1:0]  dist_mm;
    logic                         last;
  } scan_point_t;

  typedef struct {
    logic [lssq_pkg::DIST_W-1:0]  sector_min;
    logic                         sector_found;
    logic [lssq_pkg::DIST_W-1:0]  target_distance;
    logic                         target_found;
    logic [lssq_pkg::COUNT_W-1:0] valid_count;
    logic                         obstacle;
  } scan_summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lssq_pkg::ANGLE_W-1:0] in_sample_angle = '0;
  logic [lssq_pkg::DIST_W-1:0]  in_sample_distance = '0;
  logic in_scan_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [lssq_pkg::DIST_W-1:0]  out_sector_min;
  logic                         out_sector_found;
  logic [lssq_pkg::DIST_W-1:0]  out_target_distance;
  logic                         out_target_found;
  logic [lssq_pkg::COUNT_W-1:0] out_valid_count;
  logic                         out_obstacle;
  logic cfg_we = 1'b0;
  logic [lssq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lssq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lidar_scan_sector_query u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_angle     (in_sample_angle),
    .in_sample_distance  (in_sample_distance),
    .in_scan_last        (in_scan_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sector_min      (out_sector_min),
    .out_sector_found    (out_sector_found),
    .out_target_distance (out_target_distance),
    .out_target_found    (out_target_found),
    .out_valid_count     (out_valid_count),
    .out_obstacle        (out_obstacle),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register shadow
  logic [lssq_pkg::ANGLE_W-1:0] reg_start  = lssq_pkg::RST_SECTOR_START;
  logic [lssq_pkg::ANGLE_W-1:0] reg_end    = lssq_pkg::RST_SECTOR_END;
  logic [lssq_pkg::ANGLE_W-1:0] reg_target = lssq_pkg::RST_TARGET_ANGLE;
  logic [lssq_pkg::TOL_W-1:0]   reg_tol    = lssq_pkg::RST_ANGLE_TOL;
  logic [lssq_pkg::DIST_W-1:0]  reg_thresh = lssq_pkg::RST_OBST_THRESH;
  logic [lssq_pkg::DIST_W-1:0]  reg_rmin   = lssq_pkg::RST_MIN_RANGE;
  logic [lssq_pkg::DIST_W-1:0]  reg_rmax   = lssq_pkg::RST_MAX_RANGE;

  // scan accumulators
  logic [lssq_pkg::DIST_W-1:0]  acc_min = '0;
  logic                         acc_min_seen = 1'b0;
  logic [lssq_pkg::TOL_W-1:0]   acc_best_diff = '0;
  logic [lssq_pkg::DIST_W-1:0]  acc_best_dist = '0;
  logic                         acc_best_seen = 1'b0;
  logic [lssq_pkg::COUNT_W-1:0] acc_count = '0;

  scan_point_t   points_to_send[$];
  scan_summary_t summaries_due[$];

  int  err_cnt = 0;
  bit  idle_on = 1'b1;
  int  gap_left = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  int  burst_ask = 0;
  int  burst_done = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void fold_point(logic [lssq_pkg::ANGLE_W-1:0] raw_angle,
                                     logic [lssq_pkg::DIST_W-1:0] dist_mm, logic last);
    int a, t, diff;
    bit in_sec;
    scan_summary_t s;
    a = int'(raw_angle);
    if (a >= TURN) a -= TURN;
    if (dist_mm != 0 && dist_mm >= reg_rmin && dist_mm <= reg_rmax) begin
      if (acc_count != COUNT_SAT) acc_count++;
      if (reg_start <= reg_end) in_sec = a >= reg_start && a <= reg_end;
      else in_sec = a >= reg_start || a <= reg_end;
      if (in_sec && dist_mm < (acc_min_seen ? acc_min : reg_rmax)) begin
        acc_min = dist_mm;
        acc_min_seen = 1'b1;
      end
      t = int'(reg_target);
      if (t >= TURN) t -= TURN;
      diff = (a >= t) ? a - t : t - a;
      if (diff > HALF) diff = TURN - diff;
      if (diff <= reg_tol && (!acc_best_seen || diff < acc_best_diff)) begin
        acc_best_diff = 12'(diff);
        acc_best_dist = dist_mm;
        acc_best_seen = 1'b1;
      end
    end
    if (last) begin
      s.sector_min      = acc_min_seen ? acc_min : '0;
      s.sector_found    = acc_min_seen;
      s.target_distance = acc_best_seen ? acc_best_dist : '0;
      s.target_found    = acc_best_seen;
      s.valid_count     = acc_count;
      s.obstacle        = acc_min_seen && acc_min > 0 && acc_min < reg_thresh;
      summaries_due.push_back(s);
      acc_min = '0;
      acc_min_seen = 1'b0;
      acc_best_seen = 1'b0;
      acc_best_dist = '0;
      acc_count = '0;
    end
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // input sampling and result checking
  always @(posedge clk) begin
    scan_summary_t s;
    if (rst_n) begin
      if (in_valid && !in_stall) fold_point(in_sample_angle, in_sample_distance, in_scan_last);
      if (out_valid && !out_stall) begin
        if (summaries_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual min %0d found %0b",
                   $time, out_sector_min, out_sector_found);
          $display("  target %0d found %0b count %0d obstacle %0b", out_target_distance,
                   out_target_found, out_valid_count, out_obstacle);
          err_cnt++;
        end else begin
          s = summaries_due.pop_front();
          check_field("sector_min", s.sector_min, out_sector_min);
          check_field("sector_found", s.sector_found, out_sector_found);
          check_field("target_distance", s.target_distance, out_target_distance);
          check_field("target_found", s.target_found, out_target_found);
          check_field("valid_count", s.valid_count, out_valid_count);
          check_field("obstacle", s.obstacle, out_obstacle);
        end
      end
    end
  end

  // point driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) void'(points_to_send.pop_front());
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (points_to_send.size() > 0) begin
        in_valid           <= 1'b1;
        in_sample_angle    <= points_to_send[0].angle;
        in_sample_distance <= points_to_send[0].dist_mm;
        in_scan_last       <= points_to_send[0].last;
        gap_left           <= idle_on ? rand_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (burst_ask != burst_done) begin
      burst_done <= burst_done + 1;
      burst_left <= 250;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      g = idle_on ? rand_gap() : 0;
      out_stall <= g > 0;
      hold_left <= (g > 0) ? g - 1 : 0;
    end
  end

  task automatic write_reg(lssq_pkg::cfg_idx_t idx, logic [lssq_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      lssq_pkg::CFG_SECTOR_START: reg_start  = val[lssq_pkg::ANGLE_W-1:0];
      lssq_pkg::CFG_SECTOR_END:   reg_end    = val[lssq_pkg::ANGLE_W-1:0];
      lssq_pkg::CFG_TARGET_ANGLE: reg_target = val[lssq_pkg::ANGLE_W-1:0];
      lssq_pkg::CFG_ANGLE_TOL:    reg_tol    = val[lssq_pkg::TOL_W-1:0];
      lssq_pkg::CFG_OBST_THRESH:  reg_thresh = val;
      lssq_pkg::CFG_MIN_RANGE:    reg_rmin   = val;
      lssq_pkg::CFG_MAX_RANGE:    reg_rmax   = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(int s0, int s1, int tg, int tol, int th, int rmin, int rmax);
    write_reg(lssq_pkg::CFG_SECTOR_START, 16'(s0));
    write_reg(lssq_pkg::CFG_SECTOR_END, 16'(s1));
    write_reg(lssq_pkg::CFG_TARGET_ANGLE, 16'(tg));
    write_reg(lssq_pkg::CFG_ANGLE_TOL, 16'(tol));
    write_reg(lssq_pkg::CFG_OBST_THRESH, 16'(th));
    write_reg(lssq_pkg::CFG_MIN_RANGE, 16'(rmin));
    write_reg(lssq_pkg::CFG_MAX_RANGE, 16'(rmax));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_point(int a, int d, bit last);
    scan_point_t p;
    p.angle   = 13'(a);
    p.dist_mm = 16'(d);
    p.last    = last;
    points_to_send.push_back(p);
  endtask

  task automatic wait_drained();
    while (points_to_send.size() != 0 || in_valid || summaries_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic int pick_reg(int lo, int hi, int wide);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, wide) : $urandom_range(lo, hi);
  endfunction

  task automatic random_regs();
    int rmin, rmax;
    rmin = pick_reg(0, 400, 65535);
    rmax = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(rmin, rmin + 8000);
    set_regs(pick_reg(0, 5759, 65535), pick_reg(0, 5759, 65535), pick_reg(0, 5759, 65535),
             pick_reg(0, 200, 65535), pick_reg(0, 3000, 65535), rmin, rmax);
  endtask

  function automatic int make_angle();
    int r, t, off;
    r = $urandom_range(0, 99);
    t = int'(reg_target);
    if (t >= TURN) t -= TURN;
    if (r < 30) begin
      off = $urandom_range(0, (reg_tol + 2 > HALF) ? HALF : reg_tol + 2);
      return $urandom_range(0, 1) ? (t + off) % TURN : (t + TURN - off) % TURN;
    end
    if (r < 55 && reg_start <= reg_end && reg_start < TURN)
      return $urandom_range(reg_start, (reg_end < TURN) ? reg_end : TURN - 1);
    if (r < 95) return $urandom_range(0, TURN - 1);
    return $urandom_range(0, (1 << lssq_pkg::ANGLE_W) - 1);
  endfunction

  function automatic int make_dist();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(reg_rmin, reg_rmax);
    if (r < 78) return 0;
    if (r < 88) return $urandom_range(0, 65535);
    if (r < 94) begin
      case ($urandom_range(0, 3))
        0: return reg_rmin;
        1: return reg_rmax;
        2: return (reg_rmin + 65535) % 65536;
        default: return (reg_rmax + 1) % 65536;
      endcase
    end
    return (reg_thresh + $urandom_range(0, 2) + 65535) % 65536;
  endfunction

  task automatic random_scans(int n_items, bit short_only, bit end_open);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if (short_only) len = $urandom_range(1, 4);
      else len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30) : $urandom_range(31, 400);
      for (int i = 0; i < len; i++) begin
        sent++;
        if (end_open && sent == n_items) begin
          add_point(make_angle(), make_dist(), 1'b0);
          break;
        end
        add_point(make_angle(), make_dist(), i == len - 1);
      end
    end
  endtask

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: full sector, target 0, tolerance 16
    add_point(0, 0, 0);
    add_point(100, 149, 0);
    add_point(200, 12001, 0);
    add_point(300, 65535, 0);
    add_point(5759, 12000, 0);
    add_point(5760, 150, 0);
    add_point(8191, 400, 0);
    add_point(16, 300, 0);
    add_point(0, 200, 1);
    add_point(10, 0, 1);
    add_point(4000, 600, 0);
    add_point(17, 800, 1);
    wait_drained();

    // wrapped sector, zero tolerance, full range
    set_regs(5000, 300, 5750, 0, 65535, 0, 65535);
    add_point(5750, 65535, 0);
    add_point(300, 1, 0);
    add_point(301, 0, 0);
    add_point(4999, 5, 0);
    add_point(1, 65534, 1);
    wait_drained();

    // empty sector, target above a turn, widest tolerance, single valid distance
    set_regs(8191, 8191, 8000, 4095, 0, 1000, 1000);
    add_point(2240, 999, 0);
    add_point(100, 1000, 0);
    add_point(8191, 1000, 1);
    wait_drained();

    // min above max: nothing valid
    set_regs(6000, 100, 0, 16, 500, 2000, 1000);
    add_point(50, 1500, 0);
    add_point(50, 1000, 0);
    add_point(50, 2000, 1);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      random_regs();
      idle_on = (ph % 4) != 1;
      if (ph == 2) burst_ask++;
      random_scans(200, ph == 2, ph % 3 == 0);
      wait_drained();
    end
    // close any open scan
    add_point(make_angle(), make_dist(), 1'b1);
    wait_drained();
    repeat (20) @(posedge clk);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/lssq_pkg.sv
sv/lssq_point_eval.sv
sv/lidar_scan_sector_query.sv
sv/lssq_checker.sv
sim/tb_lidar_scan_sector_query.sv
